// File: rtl/tam_pkg.sv
// shared types and constants for the threshold alarm monitor
package tam_pkg;

   localparam int SOIL_SENSORS = 4;
   localparam int ZONE_COUNT   = 4;
   localparam int BIT_LANES    = 4;

   localparam logic [14:0] HOLDOFF_TICKS = 15'd30000;
   localparam logic [15:0] PHASE_TICKS   = 16'd200;
   localparam logic [2:0]  PULSE_COUNT   = 3'd5;
   localparam logic [15:0] TIMER_MAX     = 16'hFFFF;
   localparam logic signed [2:0] ZONE_NONE = -3'sd1;

   typedef enum logic [3:0] {
      ALARM_IDLE     = 4'd0,
      ALARM_OVER_T   = 4'd1,
      ALARM_UNDER_T  = 4'd2,
      ALARM_HIGH_H   = 4'd3,
      ALARM_LOW_H    = 4'd4,
      ALARM_CLIMATE  = 4'd5,
      ALARM_CLOCK    = 4'd6,
      ALARM_CARD     = 4'd7,
      ALARM_SOIL     = 4'd8
   } alarm_code_type;

   typedef enum logic [2:0] {
      CSR_TEMP_HIGH  = 3'd0,
      CSR_TEMP_LOW   = 3'd1,
      CSR_HUM_HIGH   = 3'd2,
      CSR_HUM_LOW    = 3'd3,
      CSR_ENABLE     = 3'd4,
      CSR_INTERVAL   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [11:0] temp_high;
      logic signed [11:0] temp_low;
      logic [9:0]         hum_high;
      logic [9:0]         hum_low;
      logic [3:0]         enable_mask;
      logic [15:0]        check_interval;
   } cfg_type;

   typedef struct packed {
      alarm_code_type     code;
      logic signed [2:0]  zone;
      logic               fault;
   } eval_type;

endpackage

// File: rtl/tam_csr.sv
// configuration register file of the threshold alarm monitor
module tam_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_wdata,
   output tam_pkg::cfg_type cfg
);
   import tam_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TEMP_HIGH: cfg_in.temp_high      = csr_wdata[11:0];
            CSR_TEMP_LOW:  cfg_in.temp_low       = csr_wdata[11:0];
            CSR_HUM_HIGH:  cfg_in.hum_high       = csr_wdata[9:0];
            CSR_HUM_LOW:   cfg_in.hum_low        = csr_wdata[9:0];
            CSR_ENABLE:    cfg_in.enable_mask    = csr_wdata[3:0];
            CSR_INTERVAL:  cfg_in.check_interval = csr_wdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.temp_high      <= 12'sd350;
         cfg_ff.temp_low       <= 12'sd100;
         cfg_ff.hum_high       <= 10'd900;
         cfg_ff.hum_low        <= 10'd300;
         cfg_ff.enable_mask    <= 4'hF;
         cfg_ff.check_interval <= 16'd5000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/tam_eval.sv
// fault evaluation: first fault code, soil zone and any-fault flag for the clear test
module tam_eval (
   input  tam_pkg::cfg_type  cfg,
   input  logic signed [11:0] temperature,
   input  logic [9:0]        humidity,
   input  logic              climate_ok,
   input  logic              clock_ok,
   input  logic              card_ok,
   input  logic [3:0]        soil_error_bits,
   input  logic [3:0]        smart_zone_bits,
   input  logic [3:0]        zone_alarm_bits,
   output tam_pkg::eval_type result
);
   import tam_pkg::*;

   logic t_hi, t_lo, h_hi, h_lo, en_cl;
   logic [BIT_LANES-1:0] soil_hit;
   logic [BIT_LANES-1:0] zone_mask;

   always_comb begin
      en_cl = cfg.enable_mask[0];
      t_hi  = temperature > cfg.temp_high;
      t_lo  = (temperature > 12'sd0) && (temperature < cfg.temp_low);
      h_hi  = humidity > cfg.hum_high;
      h_lo  = (humidity != 10'd0) && (humidity < cfg.hum_low);
      for (int i = 0; i < BIT_LANES; i++) begin
         soil_hit[i]  = (i < SOIL_SENSORS) && (i < ZONE_COUNT) &&
                        soil_error_bits[i] && smart_zone_bits[i];
         zone_mask[i] = (i < ZONE_COUNT);
      end
   end

   // first fault in priority order
   always_comb begin
      result.code = ALARM_IDLE;
      result.zone = ZONE_NONE;
      priority if (en_cl && climate_ok && t_hi)   result.code = ALARM_OVER_T;
      else if (en_cl && climate_ok && t_lo)       result.code = ALARM_UNDER_T;
      else if (en_cl && climate_ok && h_hi)       result.code = ALARM_HIGH_H;
      else if (en_cl && climate_ok && h_lo)       result.code = ALARM_LOW_H;
      else if (en_cl && !climate_ok)              result.code = ALARM_CLIMATE;
      else if (cfg.enable_mask[1] && !clock_ok)   result.code = ALARM_CLOCK;
      else if (cfg.enable_mask[2] && !card_ok)    result.code = ALARM_CARD;
      else if (cfg.enable_mask[3] && (soil_hit != '0)) begin
         result.code = ALARM_SOIL;
         for (int i = BIT_LANES - 1; i >= 0; i--) begin
            if (soil_hit[i]) result.zone = 3'(i);
         end
      end
      else                                        result.code = ALARM_IDLE;
      // clear test ignores the soil enable and includes zone flags
      result.fault = (en_cl && climate_ok && (t_hi || t_lo || h_hi || h_lo)) ||
                     (en_cl && !climate_ok) ||
                     (cfg.enable_mask[1] && !clock_ok) ||
                     (cfg.enable_mask[2] && !card_ok) ||
                     (soil_hit != '0) ||
                     ((zone_alarm_bits & zone_mask) != '0);
   end

endmodule

// File: rtl/threshold_alarm_monitor_with_buzzer_top.sv
// top level of the threshold alarm monitor with buzzer driver
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-------------------------------------------
//  req     | in  | req_valid/req_ready   | one tick: readings, status flags, beep
//  rsp     | out | rsp_valid/rsp_ready   | buzzer level, alarm state, raise/clear
//  csr     | in  | csr_valid/csr_ready   | csr_index, csr_wdata (always ready)
//
// one beat per cycle sustained while rsp_ready stays high; a tick's result reaches rsp through
// the input register, which takes the beat, and then the state registers, which update state and result
// reset clears all alarm and buzzer state and loads register defaults
// a stalled rsp holds the result register; the input register still takes a
// beat when the result register is free or being drained this cycle
module threshold_alarm_monitor_with_buzzer_top (
   input  logic               clock,
   input  logic               reset,
   // configuration
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   // tick input
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [11:0] req_temperature,
   input  logic [9:0]         req_humidity,
   input  logic               req_climate_ok,
   input  logic               req_clock_ok,
   input  logic               req_card_ok,
   input  logic [3:0]         req_soil_error_bits,
   input  logic [3:0]         req_smart_zone_bits,
   input  logic [3:0]         req_zone_alarm_bits,
   input  logic               req_beep_request,
   input  logic [15:0]        req_beep_ms,
   // result output
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_buzzer_on,
   output logic               rsp_alarm_active,
   output logic [3:0]         rsp_alarm_code,
   output logic signed [2:0]  rsp_alarm_zone,
   output logic               rsp_alarm_raised,
   output logic               rsp_alarm_cleared
);
   import tam_pkg::*;

   cfg_type  cfg;
   eval_type ev;

   // pipeline control
   logic pipe_adv;
   logic step;
   logic in_valid_ff, in_valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   // input register
   logic signed [11:0] temp_ff;
   logic [9:0]         hum_ff;
   logic               climate_ok_ff, clock_ok_ff, card_ok_ff;
   logic [3:0]         soil_ff, smart_ff, zalarm_ff;
   logic               beep_req_ff;
   logic [15:0]        beep_ms_ff;

   // monitor state
   logic [15:0]        check_timer_ff, check_timer_in;
   logic [14:0]        holdoff_ff, holdoff_in;
   logic               active_ff, active_in;
   alarm_code_type     code_ff, code_in;
   logic signed [2:0]  zone_ff, zone_in;
   logic               busy_ff, busy_in;
   logic               pattern_ff, pattern_in;
   logic               level_ff, level_in;
   logic [15:0]        btimer_ff, btimer_in;
   logic [2:0]         beeps_ff, beeps_in;
   logic               raised_ff, raised_in;
   logic               cleared_ff, cleared_in;

   tam_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tam_eval u_eval (
      .cfg             (cfg),
      .temperature     (temp_ff),
      .humidity        (hum_ff),
      .climate_ok      (climate_ok_ff),
      .clock_ok        (clock_ok_ff),
      .card_ok         (card_ok_ff),
      .soil_error_bits (soil_ff),
      .smart_zone_bits (smart_ff),
      .zone_alarm_bits (zalarm_ff),
      .result          (ev)
   );

   // whole pipeline moves when the result register is empty or draining
   assign pipe_adv     = !rsp_valid_ff || rsp_ready;
   assign req_ready    = pipe_adv;
   assign step         = in_valid_ff && pipe_adv;
   assign in_valid_in  = pipe_adv ? req_valid : in_valid_ff;
   assign rsp_valid_in = pipe_adv ? in_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload capture, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && pipe_adv) begin
         temp_ff       <= req_temperature;
         hum_ff        <= req_humidity;
         climate_ok_ff <= req_climate_ok;
         clock_ok_ff   <= req_clock_ok;
         card_ok_ff    <= req_card_ok;
         soil_ff       <= req_soil_error_bits;
         smart_ff      <= req_smart_zone_bits;
         zalarm_ff     <= req_zone_alarm_bits;
         beep_req_ff   <= req_beep_request;
         beep_ms_ff    <= req_beep_ms;
      end
   end

   // one tick of the monitor: timers, beep request, check, buzzer
   always_comb begin
      check_timer_in = check_timer_ff;
      holdoff_in     = holdoff_ff;
      active_in      = active_ff;
      code_in        = code_ff;
      zone_in        = zone_ff;
      busy_in        = busy_ff;
      pattern_in     = pattern_ff;
      level_in       = level_ff;
      btimer_in      = btimer_ff;
      beeps_in       = beeps_ff;
      raised_in      = 1'b0;
      cleared_in     = 1'b0;

      if (step) begin
         // free-running timers, both saturate
         if (holdoff_in < HOLDOFF_TICKS) holdoff_in = holdoff_in + 15'd1;
         if (check_timer_in != TIMER_MAX) check_timer_in = check_timer_in + 16'd1;
         if (busy_in && (btimer_in != 16'd0)) btimer_in = btimer_in - 16'd1;

         // single beep overrides any running pattern
         if (beep_req_ff) begin
            busy_in    = 1'b1;
            pattern_in = 1'b0;
            beeps_in   = 3'd0;
            level_in   = 1'b1;
            btimer_in  = beep_ms_ff;
         end

         if (check_timer_in >= cfg.check_interval) begin
            check_timer_in = 16'd0;
            // raise unless a recent alarm still stands
            if ((ev.code != ALARM_IDLE) && !(active_in && (holdoff_in < HOLDOFF_TICKS))) begin
               code_in    = ev.code;
               zone_in    = ev.zone;
               holdoff_in = 15'd0;
               active_in  = 1'b1;
               raised_in  = 1'b1;
               busy_in    = 1'b1;
               pattern_in = 1'b1;
               beeps_in   = PULSE_COUNT;
               level_in   = 1'b1;
               btimer_in  = PHASE_TICKS;
            end
            // auto clear when nothing is wrong
            if (active_in && !ev.fault) begin
               active_in  = 1'b0;
               code_in    = ALARM_IDLE;
               zone_in    = ZONE_NONE;
               cleared_in = 1'b1;
            end
         end

         // buzzer sequencing
         if (busy_in && (btimer_in == 16'd0)) begin
            if (!pattern_in) begin
               busy_in  = 1'b0;
               level_in = 1'b0;
            end else begin
               btimer_in = PHASE_TICKS;
               level_in  = !level_in;
               // each falling edge ends one pulse
               if (!level_in) begin
                  if (beeps_in != 3'd0) beeps_in = beeps_in - 3'd1;
                  if (beeps_in == 3'd0) begin
                     busy_in  = 1'b0;
                     level_in = 1'b0;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         check_timer_ff <= 16'd0;
         holdoff_ff     <= 15'd0;
         active_ff      <= 1'b0;
         code_ff        <= ALARM_IDLE;
         zone_ff        <= ZONE_NONE;
         busy_ff        <= 1'b0;
         pattern_ff     <= 1'b0;
         level_ff       <= 1'b0;
         btimer_ff      <= 16'd0;
         beeps_ff       <= 3'd0;
         raised_ff      <= 1'b0;
         cleared_ff     <= 1'b0;
      end else begin
         check_timer_ff <= check_timer_in;
         holdoff_ff     <= holdoff_in;
         active_ff      <= active_in;
         code_ff        <= code_in;
         zone_ff        <= zone_in;
         busy_ff        <= busy_in;
         pattern_ff     <= pattern_in;
         level_ff       <= level_in;
         btimer_ff      <= btimer_in;
         beeps_ff       <= beeps_in;
         if (step) begin
            raised_ff  <= raised_in;
            cleared_ff <= cleared_in;
         end
      end
   end

   // the state registers double as the result register
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_buzzer_on     = level_ff;
   assign rsp_alarm_active  = active_ff;
   assign rsp_alarm_code    = code_ff;
   assign rsp_alarm_zone    = zone_ff;
   assign rsp_alarm_raised  = raised_ff;
   assign rsp_alarm_cleared = cleared_ff;

   // a tick cannot both raise and clear
   a_raise_clear_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_alarm_raised && rsp_alarm_cleared))
      else $error("alarm raised and cleared in one tick");

   // a raise leaves a standing alarm with a real code and the buzzer on
   a_raise_sets_alarm: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_alarm_raised) |->
         (rsp_alarm_active && (rsp_alarm_code != ALARM_IDLE) && rsp_buzzer_on))
      else $error("raise without standing alarm");

   // no alarm means no code and no zone
   a_idle_code: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> ((code_ff == ALARM_IDLE) && (zone_ff == ZONE_NONE)))
      else $error("code held without alarm");

   // a zone only goes with a soil alarm
   a_zone_soil: assert property (@(posedge clock) disable iff (reset)
      (code_ff != ALARM_SOIL) |-> (zone_ff == ZONE_NONE))
      else $error("zone set for non-soil alarm");

endmodule
